### rtl/sbl_pkg.sv
// Shared types, constants and arithmetic helpers for the stereo biquad limiter.
`timescale 1ns / 1ps
`default_nettype none
package sbl_pkg;

  localparam int BASS_SECTIONS = 4;
  localparam int DIV_STEPS = 48;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_COEF  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] CFG_STAGE_COUNT  = 3'd0;
  localparam logic [2:0] CFG_GUARD_COUNT  = 3'd1;
  localparam logic [2:0] CFG_PRE_GAIN     = 3'd2;
  localparam logic [2:0] CFG_BASS_GAIN    = 3'd3;
  localparam logic [2:0] CFG_LEFT_GAIN    = 3'd4;
  localparam logic [2:0] CFG_RIGHT_GAIN   = 3'd5;
  localparam logic [2:0] CFG_RELEASE_RATE = 3'd6;

  localparam logic [24:0] LIM_ONE = 25'd16777216;
  localparam logic [23:0] LIM_T   = 24'd16274309;
  localparam logic [47:0] LIM_NUM = {LIM_T, 24'd0};

  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;
  localparam logic signed [47:0] S16_MAX = 48'sd32767;
  localparam logic signed [47:0] S16_MIN = -48'sd32768;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [4:0]         coef_section;
    logic [2:0]         coef_slot;
    logic signed [31:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] meter_left;
    logic signed [15:0] meter_right;
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               limit_hit;
  } out_item_t;

  function automatic logic signed [67:0] sx32(input logic signed [31:0] v);
    return {{36{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > S16_MAX) return S16_MAX[15:0];
    if (v < S16_MIN) return S16_MIN[15:0];
    return v[15:0];
  endfunction

  // Arithmetic shift right with round half up.
  function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] v,
                                                 input int unsigned s);
    logic signed [67:0] half;
    half = 68'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

  // Level after pre-gain, truncated toward zero to 16 bits.
  function automatic logic signed [15:0] meter_val(input logic signed [31:0] x);
    logic signed [32:0] t;
    t = {x[31], x} + (x[31] ? 33'sd511 : 33'sd0);
    t = t >>> 9;
    return sat16({{15{t[32]}}, t});
  endfunction

  // x * 32767 / 2^24 toward zero, saturated.
  function automatic logic signed [15:0] final_val(input logic signed [31:0] x);
    logic signed [47:0] xe;
    logic signed [47:0] v;
    xe = {{16{x[31]}}, x};
    v = (xe <<< 15) - xe;
    v = v + (v[47] ? 48'sd16777215 : 48'sd0);
    v = v >>> 24;
    return sat16(v);
  endfunction

  function automatic logic signed [31:0] rectify(input logic signed [31:0] y);
    if (y == S32_MIN[31:0]) return S32_MAX[31:0];
    if (y[31]) return -y;
    return y;
  endfunction

endpackage
`default_nettype wire

### rtl/sbl_if.sv
// Valid/ready channels for input requests and result frames.
`timescale 1ns / 1ps
`default_nettype none
interface sbl_in_if import sbl_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sbl_out_if import sbl_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/sbl_div.sv
// Restoring divider for the limiter attack gain: threshold over peak.
`timescale 1ns / 1ps
`default_nettype none
module sbl_div import sbl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [24:0] quotient
);

  logic [47:0] num;
  logic [31:0] rem;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, num[47]};
  assign fits = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && !start && (cnt == 6'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        num <= LIM_NUM;
        rem <= '0;
        dsr <= divisor;
        quotient <= '0;
      end else if (busy) begin
        // one quotient bit a cycle; upper bits are known zero and drop out
        rem <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
        quotient <= {quotient[23:0], fits};
        num <= {num[46:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/stereo_biquad_chain_limiter_core.sv
// Frame steps: accept, then per biquad section walked its coefficient and history loads and multiplies,
// the 4 bass sections plus scaling when bass is enabled, one start step per main section
// plus one, then gain, meter, limiter and hand-off (with a release update while the limiter releases),
// the divide on a limiter attack, plus any wait for the output register to free up.
// One frame at a time; the shared multiplier and single coefficient read port set this.
// Coefficient writes and history clears leave the block idle. Synchronous reset clears
// history valid bits, limiter gain to 1.0 and registers to defaults; coefficients stay.
`timescale 1ns / 1ps
`default_nettype none
module stereo_biquad_chain_limiter_core import sbl_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic          clk,
  input  logic          rst,
  sbl_in_if.sink        in_ch,
  sbl_out_if.source     out_ch,
  input  logic          cfg_write,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  localparam int SECTIONS = STAGES + BASS_SECTIONS;
  localparam int SEC_W = $clog2(SECTIONS);
  localparam int CDEPTH = SECTIONS * 5;
  localparam int CADDR_W = $clog2(CDEPTH);
  localparam int HDEPTH = SECTIONS * 4;
  localparam int HADDR_W = SEC_W + 2;
  localparam logic signed [67:0] THR = $signed({20'd0, LIM_T, 24'd0});

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LOAD, S_CALC, S_BSCALE, S_POST, S_DIV, S_APPLY, S_DONE
  } state_t;

  // configuration
  logic [4:0]  stage_count;
  logic [1:0]  guard_count;
  logic [15:0] pre_gain;
  logic [14:0] bass_gain;
  logic [7:0]  left_gain;
  logic [7:0]  right_gain;
  logic [23:0] release_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= '0;
      guard_count <= '0;
      pre_gain <= 16'd32768;
      bass_gain <= '0;
      left_gain <= '0;
      right_gain <= '0;
      release_rate <= 24'd3170;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STAGE_COUNT:  stage_count <= cfg_data[4:0];
        CFG_GUARD_COUNT:  guard_count <= cfg_data[1:0];
        CFG_PRE_GAIN:     pre_gain <= cfg_data[15:0];
        CFG_BASS_GAIN:    bass_gain <= cfg_data[14:0];
        CFG_LEFT_GAIN:    left_gain <= cfg_data[7:0];
        CFG_RIGHT_GAIN:   right_gain <= cfg_data[7:0];
        CFG_RELEASE_RATE: release_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state;
  logic [3:0]  step;
  logic [SEC_W-1:0] sec;
  logic [SECTIONS-1:0] hvalid;
  logic signed [31:0] sl, sr, sm, vb, yl, yr;
  logic signed [31:0] coef_q [5];
  logic signed [31:0] z_q [4];
  logic signed [65:0] acc;
  logic signed [65:0] p;
  logic [31:0] pk;
  logic [24:0] lim;
  logic        hit;
  logic        out_valid;
  out_item_t   out_q;
  logic signed [15:0] meter_l, meter_r;

  logic in_acc;
  assign in_ch.ready = (state == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_q;

  // coefficient memory
  logic signed [31:0] coef_mem [CDEPTH];
  logic signed [31:0] coef_rd;
  logic [CADDR_W-1:0] coef_raddr, coef_waddr;
  logic [7:0] coef_wfull;
  logic coef_we;

  assign coef_wfull = ({3'd0, in_ch.payload.coef_section} << 2)
                    + {3'd0, in_ch.payload.coef_section}
                    + {5'd0, in_ch.payload.coef_slot};
  assign coef_waddr = coef_wfull[CADDR_W-1:0];
  assign coef_we = in_acc && in_ch.payload.opcode == OP_COEF
                && ({1'b0, in_ch.payload.coef_section} < 6'(SECTIONS))
                && (in_ch.payload.coef_slot < 3'd5);
  assign coef_raddr = (CADDR_W'(sec) << 2) + CADDR_W'(sec) + CADDR_W'(step);

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_ch.payload.coef_value;
    end
    coef_rd <= coef_mem[coef_raddr];
  end

  // history memory: row per section, z1L z2L z1R z2R
  logic signed [31:0] hist_mem [HDEPTH];
  logic signed [31:0] hist_rd;
  logic [HADDR_W-1:0] hist_raddr, hist_waddr;
  logic signed [31:0] hist_wdata;
  logic hist_we;

  assign hist_raddr = {sec, step[1:0]};
  assign hist_we = (state == S_CALC)
                && (step == 4'd4 || step == 4'd6 || step == 4'd8 || step == 4'd10);
  assign hist_waddr = {sec, (step == 4'd6 || step == 4'd10), (step == 4'd8 || step == 4'd10)};

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd <= hist_mem[hist_raddr];
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [67:0] p68;
  logic bass_sec;
  logic signed [31:0] xl_in, xr_in;
  logic [24:0] lim_d;

  assign p68 = {{2{p[65]}}, p};
  assign bass_sec = sec >= SEC_W'(STAGES);
  assign xl_in = bass_sec ? sm : sl;
  assign xr_in = bass_sec ? sm : sr;
  assign lim_d = LIM_ONE - lim;

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CALC: begin
        unique case (step)
          4'd0: begin mul_a = {coef_q[0][31], coef_q[0]}; mul_b = {xl_in[31], xl_in}; end
          4'd1: begin mul_a = {coef_q[0][31], coef_q[0]}; mul_b = {xr_in[31], xr_in}; end
          4'd2: begin mul_a = {coef_q[1][31], coef_q[1]}; mul_b = {xl_in[31], xl_in}; end
          4'd3: begin mul_a = {coef_q[3][31], coef_q[3]}; mul_b = {yl[31], yl}; end
          4'd4: begin mul_a = {coef_q[1][31], coef_q[1]}; mul_b = {xr_in[31], xr_in}; end
          4'd5: begin mul_a = {coef_q[3][31], coef_q[3]}; mul_b = {yr[31], yr}; end
          4'd6: begin mul_a = {coef_q[2][31], coef_q[2]}; mul_b = {xl_in[31], xl_in}; end
          4'd7: begin mul_a = {coef_q[4][31], coef_q[4]}; mul_b = {yl[31], yl}; end
          4'd8: begin mul_a = {coef_q[2][31], coef_q[2]}; mul_b = {xr_in[31], xr_in}; end
          4'd9: begin mul_a = {coef_q[4][31], coef_q[4]}; mul_b = {yr[31], yr}; end
          default: ;
        endcase
      end
      S_BSCALE: begin
        mul_a = {sm[31], sm};
        mul_b = {18'd0, bass_gain};
      end
      S_POST: begin
        unique case (step)
          4'd0: begin mul_a = {sl[31], sl}; mul_b = {17'd0, pre_gain}; end
          4'd1: begin mul_a = {sr[31], sr}; mul_b = {17'd0, pre_gain}; end
          4'd2: begin mul_a = {sl[31], sl}; mul_b = {25'd0, left_gain}; end
          4'd3: begin mul_a = {sr[31], sr}; mul_b = {25'd0, right_gain}; end
          4'd6: begin mul_a = {1'b0, pk}; mul_b = {8'd0, lim}; end
          4'd7: begin mul_a = {8'd0, lim_d}; mul_b = {9'd0, release_rate}; end
          default: ;
        endcase
      end
      S_APPLY: begin
        mul_a = (step == 4'd0) ? {sl[31], sl} : {sr[31], sr};
        mul_b = {8'd0, lim};
      end
      default: ;
    endcase
  end

  // biquad history update
  logic signed [67:0] hdiff_rnd;
  logic signed [31:0] z2_sel;
  assign hdiff_rnd = rnd_shr({{2{acc[65]}}, acc} - p68, 28);
  assign z2_sel = (step == 4'd4) ? z_q[1] : z_q[3];
  assign hist_wdata = (step == 4'd4 || step == 4'd6) ? sat32(hdiff_rnd + sx32(z2_sel))
                                                     : sat32(hdiff_rnd);

  // section count and limiter helpers
  logic [5:0] sc6;
  logic [SEC_W-1:0] nq;
  logic [31:0] abs_l, abs_r;
  logic [67:0] rel_sum;
  logic [25:0] lim_nl;
  logic lim_gt;

  assign sc6 = {1'b0, stage_count};
  assign nq = (sc6 > 6'(STAGES)) ? SEC_W'(STAGES) : SEC_W'(sc6);
  assign abs_l = sl[31] ? 32'(-sl) : sl;
  assign abs_r = sr[31] ? 32'(-sr) : sr;
  assign rel_sum = p68 + 68'sd16777215;
  assign lim_nl = {1'b0, lim} + rel_sum[49:24];
  assign lim_gt = p68 > THR;

  logic div_start, div_done;
  logic [24:0] div_q;
  assign div_start = (state == S_POST) && (step == 4'd7) && lim_gt;

  sbl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (pk),
    .done     (div_done),
    .quotient (div_q)
  );

  logic [16:0] in_sum;
  assign in_sum = {in_ch.payload.left_sample[15], in_ch.payload.left_sample}
                + {in_ch.payload.right_sample[15], in_ch.payload.right_sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      sec <= '0;
      hvalid <= '0;
      lim <= LIM_ONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && in_ch.payload.opcode == OP_CLEAR) begin
            hvalid <= '0;
          end
          if (in_acc && in_ch.payload.opcode == OP_FRAME) begin
            sl <= {{7{in_ch.payload.left_sample[15]}}, in_ch.payload.left_sample, 9'd0};
            sr <= {{7{in_ch.payload.right_sample[15]}}, in_ch.payload.right_sample, 9'd0};
            sm <= {{7{in_sum[16]}}, in_sum, 8'd0};
            vb <= '0;
            hit <= 1'b0;
            step <= '0;
            if (bass_gain != '0) begin
              sec <= SEC_W'(STAGES);
              state <= S_LOAD;
            end else begin
              sec <= '0;
              state <= S_START;
            end
          end
        end
        S_START: begin
          if (sec == SEC_W'(guard_count)) begin
            sl <= sat32(sx32(sl) + sx32(vb));
            sr <= sat32(sx32(sr) + sx32(vb));
          end
          step <= '0;
          state <= (sec < nq) ? S_LOAD : S_POST;
        end
        S_LOAD: begin
          if (step != 4'd0) begin
            coef_q[3'(step - 4'd1)] <= coef_rd;
          end
          if (step != 4'd0 && step < 4'd5) begin
            z_q[2'(step - 4'd1)] <= hvalid[sec] ? hist_rd : '0;
          end
          if (step == 4'd5) begin
            step <= '0;
            state <= S_CALC;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_CALC: begin
          unique case (step)
            4'd1: yl <= sat32(rnd_shr(p68, 28) + sx32(z_q[0]));
            4'd2: yr <= sat32(rnd_shr(p68, 28) + sx32(z_q[2]));
            4'd3, 4'd5, 4'd7, 4'd9: acc <= p;
            4'd4: hvalid[sec] <= 1'b1;
            default: ;
          endcase
          if (step == 4'd10) begin
            step <= '0;
            if (bass_sec) begin
              sm <= (sec == SEC_W'(STAGES + 1)) ? rectify(yl) : yl;
              if (sec == SEC_W'(STAGES + 3)) begin
                state <= S_BSCALE;
              end else begin
                sec <= sec + 1'b1;
                state <= S_LOAD;
              end
            end else begin
              sl <= yl;
              sr <= yr;
              sec <= sec + 1'b1;
              state <= S_START;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        S_BSCALE: begin
          if (step == 4'd1) begin
            vb <= sat32(rnd_shr(p68, 13));
            sec <= '0;
            step <= '0;
            state <= S_START;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_POST: begin
          if (step < 4'd7) begin
            step <= step + 4'd1;
          end
          unique case (step)
            4'd1: sl <= sat32(rnd_shr(p68, 16));
            4'd2: begin
              sr <= sat32(rnd_shr(p68, 16));
              meter_l <= meter_val(sl);
            end
            4'd3: begin
              sl <= sat32(rnd_shr(p68, 8));
              meter_r <= meter_val(sr);
            end
            4'd4: sr <= sat32(rnd_shr(p68, 8));
            4'd5: pk <= (abs_l > abs_r) ? abs_l : abs_r;
            4'd7: begin
              if (lim_gt) begin
                step <= '0;
                state <= S_DIV;
              end else if (lim < LIM_ONE) begin
                step <= 4'd8;
              end else begin
                step <= '0;
                state <= S_APPLY;
              end
            end
            4'd8: begin
              lim <= (lim_nl > {1'b0, LIM_ONE}) ? LIM_ONE : lim_nl[24:0];
              step <= '0;
              state <= S_APPLY;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            lim <= div_q;
            hit <= 1'b1;
            step <= '0;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          step <= step + 4'd1;
          if (step == 4'd1) begin
            sl <= sat32(rnd_shr(p68, 24));
          end
          if (step == 4'd2) begin
            sr <= sat32(rnd_shr(p68, 24));
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output slot is free
          if (!out_valid || out_ch.ready) begin
            out_q.meter_left <= meter_l;
            out_q.meter_right <= meter_r;
            out_q.out_left <= final_val(sl);
            out_q.out_right <= final_val(sr);
            out_q.limit_hit <= hit;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result raised outside frame completion");

  a_lim_range: assert property (@(posedge clk) disable iff (rst)
    lim <= LIM_ONE)
    else $error("limiter gain above unity");

  a_nonframe_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.payload.opcode != OP_FRAME |=> state == S_IDLE)
    else $error("non-frame request started frame processing");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside attack wait");

endmodule
`default_nettype wire

### bench/tb.sv
// Self-checking bench for the stereo biquad cascade with bass, meter and limiter.
`timescale 1ns / 1ps
module tb;
  import sbl_pkg::*;

  typedef logic signed [67:0] wide_t;

  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          NUM_STAGES  = 16;
  localparam int          NUM_COEFS   = (NUM_STAGES + BASS_SECTIONS) * 5;
  localparam int          BASS_HIST   = NUM_STAGES * 4;
  localparam longint      GAIN_ONE    = 64'd16777216;
  localparam longint      PEAK_LIMIT  = 64'd16274309 << 24;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = CFG_STAGE_COUNT;
  logic [23:0] cfg_data = '0;

  sbl_in_if  in_ch ();
  sbl_out_if out_ch ();

  stereo_biquad_chain_limiter_core #(.STAGES(NUM_STAGES)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  logic signed [31:0] coef_mem [NUM_COEFS];
  logic signed [31:0] hist [NUM_STAGES * 4 + BASS_SECTIONS * 2];
  longint             lim_gain;
  int stage_cnt, guard_cnt, pre_gain, bass_gain, left_gain, right_gain, release_rate;

  out_item_t frames_due[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  function automatic wide_t rnd_shift(wide_t a, int s);
    return (a + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic wide_t trunc_shift(wide_t a, int s);
    return (a < 0) ? -((-a) >>> s) : (a >>> s);
  endfunction

  function automatic logic signed [31:0] clip32(wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] clip16(wide_t v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Transposed direct-form-II section; cb is the coefficient base, hb the history base.
  function automatic logic signed [31:0] biquad(int cb, int hb, logic signed [31:0] x);
    wide_t xx, y;
    logic signed [31:0] ys;
    xx = wide_t'(x);
    ys = clip32(rnd_shift(wide_t'(coef_mem[cb]) * xx, 28) + wide_t'(hist[hb]));
    y = wide_t'(ys);
    hist[hb] = clip32(rnd_shift(wide_t'(coef_mem[cb+1]) * xx
                                - wide_t'(coef_mem[cb+3]) * y, 28) + wide_t'(hist[hb+1]));
    hist[hb+1] = clip32(rnd_shift(wide_t'(coef_mem[cb+2]) * xx
                                  - wide_t'(coef_mem[cb+4]) * y, 28));
    return ys;
  endfunction

  function automatic void reset_model();
    foreach (hist[i]) hist[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    lim_gain = GAIN_ONE;
    stage_cnt = 0; guard_cnt = 0; pre_gain = 32768; bass_gain = 0;
    left_gain = 0; right_gain = 0; release_rate = 3170;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [23:0] v);
    case (idx)
      CFG_STAGE_COUNT:  stage_cnt = v[4:0];
      CFG_GUARD_COUNT:  guard_cnt = v[1:0];
      CFG_PRE_GAIN:     pre_gain = v[15:0];
      CFG_BASS_GAIN:    bass_gain = v[14:0];
      CFG_LEFT_GAIN:    left_gain = v[7:0];
      CFG_RIGHT_GAIN:   right_gain = v[7:0];
      CFG_RELEASE_RATE: release_rate = v;
      default: ;
    endcase
  endfunction

  // Advance the model by one request; returns 1 with the frame result if one is due.
  function automatic bit filter_frame(in_item_t it, output out_item_t res);
    logic signed [31:0] xl, xr, m, vb;
    wide_t al, ar;
    longint pk, d, inc;
    int nq;
    bit hit;
    res = '0;
    vb = '0;
    hit = 1'b0;
    if (it.opcode == OP_COEF) begin
      if (it.coef_section < NUM_STAGES + BASS_SECTIONS && it.coef_slot < 5)
        coef_mem[it.coef_section * 5 + it.coef_slot] = it.coef_value;
      return 1'b0;
    end
    if (it.opcode == OP_CLEAR) begin
      foreach (hist[i]) hist[i] = '0;
      return 1'b0;
    end
    if (it.opcode != OP_FRAME) return 1'b0;

    xl = 32'(wide_t'(it.left_sample) * 512);
    xr = 32'(wide_t'(it.right_sample) * 512);
    if (bass_gain != 0) begin
      m = 32'((wide_t'(it.left_sample) + wide_t'(it.right_sample)) * 256);
      for (int i = 0; i < 2; i++) m = biquad((NUM_STAGES + i) * 5, BASS_HIST + i * 2, m);
      if (m < 0) m = (m == 32'sh80000000) ? 32'sh7fffffff : -m;
      for (int i = 2; i < 4; i++) m = biquad((NUM_STAGES + i) * 5, BASS_HIST + i * 2, m);
      vb = clip32(rnd_shift(wide_t'(m) * wide_t'(bass_gain), 13));
    end
    nq = (stage_cnt > NUM_STAGES) ? NUM_STAGES : stage_cnt;
    for (int i = 0; i < nq; i++) begin
      if (i == guard_cnt) begin
        xl = clip32(wide_t'(xl) + wide_t'(vb));
        xr = clip32(wide_t'(xr) + wide_t'(vb));
      end
      xl = biquad(i * 5, i * 4, xl);
      xr = biquad(i * 5, i * 4 + 2, xr);
    end
    if (guard_cnt == nq) begin
      xl = clip32(wide_t'(xl) + wide_t'(vb));
      xr = clip32(wide_t'(xr) + wide_t'(vb));
    end

    xl = clip32(rnd_shift(wide_t'(xl) * wide_t'(pre_gain), 16));
    xr = clip32(rnd_shift(wide_t'(xr) * wide_t'(pre_gain), 16));
    res.meter_left = clip16(trunc_shift(wide_t'(xl), 9));
    res.meter_right = clip16(trunc_shift(wide_t'(xr), 9));
    xl = clip32(rnd_shift(wide_t'(xl) * wide_t'(left_gain), 8));
    xr = clip32(rnd_shift(wide_t'(xr) * wide_t'(right_gain), 8));

    al = (xl < 0) ? -wide_t'(xl) : wide_t'(xl);
    ar = (xr < 0) ? -wide_t'(xr) : wide_t'(xr);
    pk = (al > ar) ? longint'(al) : longint'(ar);
    if (pk * lim_gain > PEAK_LIMIT) begin
      lim_gain = PEAK_LIMIT / pk;
      hit = 1'b1;
    end else if (lim_gain < GAIN_ONE) begin
      d = GAIN_ONE - lim_gain;
      inc = (d * longint'(release_rate) + GAIN_ONE - 1) >>> 24;
      lim_gain = (lim_gain + inc > GAIN_ONE) ? GAIN_ONE : lim_gain + inc;
    end
    xl = clip32(rnd_shift(wide_t'(xl) * wide_t'(lim_gain), 24));
    xr = clip32(rnd_shift(wide_t'(xr) * wide_t'(lim_gain), 24));
    res.out_left = clip16(trunc_shift(wide_t'(xl) * 32767, 24));
    res.out_right = clip16(trunc_shift(wide_t'(xr) * 32767, 24));
    res.limit_hit = hit;
    return 1'b1;
  endfunction

  function automatic in_item_t make_req(logic [1:0] op, int l, int r, int sec, int slot,
                                        logic [31:0] val);
    in_item_t it;
    it.opcode = op;
    it.left_sample = l[15:0];
    it.right_sample = r[15:0];
    it.coef_section = sec[4:0];
    it.coef_slot = slot[2:0];
    it.coef_value = val;
    return it;
  endfunction

  function automatic out_item_t make_res(int ml, int mr);
    out_item_t o;
    o = '0;
    o.meter_left = ml[15:0];
    o.meter_right = mr[15:0];
    return o;
  endfunction

  // Coefficient values: mostly moderate, now and then anything in range.
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(32'h10000000)) - 32'sh08000000);
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // Hand one request to the block; hold valid until it is taken.
  task automatic send(in_item_t it, bit typed, out_item_t want);
    out_item_t res;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    if (filter_frame(it, res)) frames_due.push_back(typed ? want : res);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_regs(logic [23:0] vals [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      model_config(3'(i), vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        report("unexpected frame", 0, 0);
      end else begin
        want = frames_due.pop_front();
        if (out_ch.payload.meter_left != want.meter_left)
          report("meter_left", out_ch.payload.meter_left, want.meter_left);
        if (out_ch.payload.meter_right != want.meter_right)
          report("meter_right", out_ch.payload.meter_right, want.meter_right);
        if (out_ch.payload.out_left != want.out_left)
          report("out_left", out_ch.payload.out_left, want.out_left);
        if (out_ch.payload.out_right != want.out_right)
          report("out_right", out_ch.payload.out_right, want.out_right);
        if (out_ch.payload.limit_hit != want.limit_hit)
          report("limit_hit", out_ch.payload.limit_hit, want.limit_hit);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } step_t;

  initial begin
    step_t       steps[$];
    logic [23:0] regs [7];
    in_item_t    it;
    int          pick;

    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: no sections, half pre-gain, zero volume.
    steps.push_back('{make_req(OP_FRAME, 32767, -32768, 0, 0, 0), 1, make_res(16383, -16384)});
    steps.push_back('{make_req(OP_FRAME, 0, 0, 31, 7, '1), 1, make_res(0, 0)});
    steps.push_back('{make_req(OP_FRAME, -1, 1, 0, 0, 0), 1, make_res(0, 0)});
    steps.push_back('{make_req(OP_FRAME, -32768, 32767, 0, 0, 0), 1, make_res(-16384, 16383)});
    steps.push_back('{make_req(OP_COEF, 0, 0, 0, 0, 32'h7fffffff), 0, '0});
    steps.push_back('{make_req(OP_COEF, -1, -1, 19, 4, 32'h80000000), 0, '0});
    steps.push_back('{make_req(OP_COEF, 0, 0, 20, 0, 32'h12345678), 0, '0});
    steps.push_back('{make_req(OP_COEF, 0, 0, 31, 7, 32'hffffffff), 0, '0});
    steps.push_back('{make_req(OP_COEF, 0, 0, 3, 5, 32'h00000001), 0, '0});
    steps.push_back('{make_req(OP_CLEAR, 5, 5, 0, 0, 0), 0, '0});
    steps.push_back('{make_req(OP_UNUSED, -32768, 32767, 19, 4, 32'h80000000), 0, '0});
    steps.push_back('{make_req(OP_FRAME, 100, -100, 0, 0, 0), 1, make_res(50, -50)});
    steps.push_back('{make_req(OP_FRAME, 1234, -4321, 0, 0, 0), 0, '0});
    foreach (steps[i]) send(steps[i].req, steps[i].typed, steps[i].want);

    // Load every coefficient so no frame reads an unwritten one.
    for (int s = 0; s < NUM_STAGES + BASS_SECTIONS; s++)
      for (int k = 0; k < 5; k++)
        send(make_req(OP_COEF, $urandom, $urandom, s, k,
                      (k == 0) ? 32'($urandom_range(32'h0c000000, 32'h02000000))
                               : 32'($signed($urandom_range(32'h04000000)) - 32'sh02000000)),
             0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) begin
        regs = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      end else if (ph == 1) begin
        regs = '{24'd31, 24'd3, 24'hffff, 24'h7fff, 24'hff, 24'hff, 24'hffffff};
      end else begin
        regs[0] = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
        regs[1] = $urandom_range(3);
        regs[2] = $urandom_range(16'hffff);
        regs[3] = $urandom_range(1) ? $urandom_range(15'h7fff) : 24'd0;
        regs[4] = $urandom_range(255);
        regs[5] = $urandom_range(255);
        regs[6] = $urandom_range(1) ? $urandom_range(24'hffffff) : $urandom_range(20000);
      end
      write_regs(regs);
      send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 6 : 50) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 6 : 50) : 0;

      for (int n = 0; n < 170; n++) begin
        pick = $urandom_range(99);
        if (pick < 85)
          it = make_req(OP_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 93)
          it = make_req(OP_COEF, $urandom, $urandom, $urandom_range(31), $urandom_range(7),
                        rand_coef());
        else if (pick < 97)
          it = make_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
          it = make_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
        send(it, 0, '0);
      end
    end

    wait_idle();
    repeat (500) @(posedge clk);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
